/* src/mie_pkg.sv */
// Shared constants, types and queue control records for the SSID extractor.
`default_nettype none
package mie_pkg;

  localparam int SSID_MAX = 32;
  localparam int IDX_W = 5;
  localparam int LEN_W = 6;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  localparam int BYTE_DEPTH_DEF = 64;
  localparam int DESC_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_ID,
    PH_LEN,
    PH_VAL
  } phase_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] off;
    logic [7:0]       data;
    logic             commit;
    logic [LEN_W-1:0] len;
  } q_wr_t;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] len;
  } q_desc_t;

  typedef struct packed {
    logic rd_en;
    logic pop;
  } q_rd_t;

endpackage
`default_nettype wire

/* src/mie_frame_if.sv */
// Frame body byte channel.
`default_nettype none
interface mie_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       frame_end;
  logic [7:0] fixed_len;

  modport source(output valid, data_byte, frame_start, frame_end, fixed_len, input ready);
  modport sink(input valid, data_byte, frame_start, frame_end, fixed_len, output ready);
endinterface
`default_nettype wire

/* src/mie_ssid_if.sv */
// SSID result byte channel.
`default_nettype none
interface mie_ssid_if;
  logic       valid;
  logic       ready;
  logic [7:0] ssid_byte;
  logic [4:0] ssid_index;
  logic [5:0] ssid_length;
  logic       last;

  modport source(output valid, ssid_byte, ssid_index, ssid_length, last, input ready);
  modport sink(input valid, ssid_byte, ssid_index, ssid_length, last, output ready);
endinterface
`default_nettype wire

/* src/mie_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/mie_front.sv */
// Element walker: skips fixed fields, checks SSID elements, stages bytes and commits runs.
`default_nettype none
module mie_front (
  input  wire logic           clk,
  input  wire logic           rst,
  mie_frame_if.sink           frame,
  input  wire logic           space_ok,
  output mie_pkg::q_wr_t      wr
);
  import mie_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  element_id, element_id_next;
  logic [7:0]  element_length, element_length_next;
  logic [7:0]  value_position, value_position_next;
  logic        all_printable, all_printable_next;
  logic        differs, differs_next;
  logic [7:0]  cand [SSID_MAX];
  logic [7:0]  stored [SSID_MAX];

  logic             accept;
  phase_t           ph_in, ph_eff;
  logic [7:0]       bl_in;
  logic             is_cand, printable, ap_upd, diff_upd, done, commit, cand_wr;
  logic [7:0]       pos_inc;
  logic [IDX_W-1:0] pos_idx;

  assign frame.ready = space_ok;
  assign accept      = frame.valid && space_ok;
  assign pos_idx     = value_position[IDX_W-1:0];

  always_comb begin
    ph_in     = frame.frame_start ? PH_SKIP : phase;
    bl_in     = frame.frame_start ? frame.fixed_len : bytes_left;
    ph_eff    = (ph_in == PH_SKIP && bl_in == 8'd0) ? PH_ID : ph_in;
    is_cand   = (element_id == 8'd0) && (element_length <= 8'(SSID_MAX));
    printable = frame.data_byte inside {[PRINT_LO:PRINT_HI]};
    ap_upd    = is_cand ? (all_printable && printable) : all_printable;
    diff_upd  = is_cand ? (differs || (frame.data_byte != stored[pos_idx])) : differs;
    pos_inc   = value_position + 8'd1;
    done      = pos_inc >= element_length;
    cand_wr   = accept && (ph_eff == PH_VAL) && is_cand;
    commit    = cand_wr && done && ap_upd && diff_upd;
  end

  // next state
  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    element_id_next     = element_id;
    element_length_next = element_length;
    value_position_next = value_position;
    all_printable_next  = all_printable;
    differs_next        = differs;
    if (accept) begin
      phase_next      = ph_eff;
      bytes_left_next = bl_in;
      case (ph_eff)
        PH_SKIP: begin
          bytes_left_next = bl_in - 8'd1;
        end
        PH_ID: begin
          element_id_next = frame.data_byte;
          phase_next      = PH_LEN;
        end
        PH_LEN: begin
          element_length_next = frame.data_byte;
          value_position_next = 8'd0;
          all_printable_next  = 1'b1;
          differs_next        = 1'b0;
          phase_next          = (frame.data_byte == 8'd0) ? PH_ID : PH_VAL;
        end
        PH_VAL: begin
          all_printable_next  = ap_upd;
          differs_next        = diff_upd;
          value_position_next = pos_inc;
          if (done) begin
            phase_next = PH_ID;
          end
        end
        default: begin
          phase_next = PH_SKIP;
        end
      endcase
      if (frame.frame_end) begin
        phase_next      = PH_SKIP;
        bytes_left_next = 8'd0;
      end
    end
  end

  // outputs to the queue
  always_comb begin
    wr.we     = cand_wr;
    wr.off    = pos_idx;
    wr.data   = frame.data_byte;
    wr.commit = commit;
    wr.len    = element_length[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SKIP;
      bytes_left     <= 8'd0;
      element_id     <= 8'd0;
      element_length <= 8'd0;
      value_position <= 8'd0;
      all_printable  <= 1'b1;
      differs        <= 1'b0;
    end else begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      element_id     <= element_id_next;
      element_length <= element_length_next;
      value_position <= value_position_next;
      all_printable  <= all_printable_next;
      differs        <= differs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_wr) begin
      cand[pos_idx] <= frame.data_byte;
    end
  end

  // stored SSID: new bytes below the length, a zero at it, older bytes above
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SSID_MAX; i++) begin
        stored[i] <= 8'd0;
      end
    end else if (commit) begin
      for (int i = 0; i < SSID_MAX; i++) begin
        if (8'(i) < element_length) begin
          stored[i] <= (IDX_W'(i) == pos_idx) ? frame.data_byte : cand[i];
        end else if (8'(i) == element_length) begin
          stored[i] <= 8'd0;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/mie_queue.sv */
// Staging byte buffer and run descriptor queue between walker and emitter.
`default_nettype none
module mie_queue #(
  parameter int BYTE_DEPTH = mie_pkg::BYTE_DEPTH_DEF,
  parameter int DESC_DEPTH = mie_pkg::DESC_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire mie_pkg::q_wr_t wr,
  output logic           space_ok,
  input  wire mie_pkg::q_rd_t rd,
  output mie_pkg::q_desc_t desc,
  output logic [7:0]     rdata
);
  import mie_pkg::*;

  localparam int AW = $clog2(BYTE_DEPTH);
  localparam int DW = $clog2(DESC_DEPTH);
  localparam logic [AW:0] SPACE_LIM = (AW+1)'(BYTE_DEPTH - SSID_MAX);
  localparam logic [DW:0] DESC_FULL = (DW+1)'(DESC_DEPTH);

  logic [AW:0]      commit_ptr, rd_ptr, used;
  logic [DW:0]      dwp, drp, dcnt;
  logic [LEN_W-1:0] dq [DESC_DEPTH];
  logic [AW-1:0]    waddr;

  assign used     = commit_ptr - rd_ptr;
  assign dcnt     = dwp - drp;
  assign space_ok = (used <= SPACE_LIM) && (dcnt != DESC_FULL);
  assign waddr    = commit_ptr[AW-1:0] + AW'(wr.off);

  assign desc.valid = dwp != drp;
  assign desc.len   = dq[drp[DW-1:0]];

  mie_ram #(
    .WIDTH(8),
    .DEPTH(BYTE_DEPTH)
  ) u_bytes (
    .clk  (clk),
    .we   (wr.we),
    .waddr(waddr),
    .wdata(wr.data),
    .re   (rd.rd_en),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      commit_ptr <= '0;
      rd_ptr     <= '0;
      dwp        <= '0;
      drp        <= '0;
    end else begin
      if (wr.commit) begin
        commit_ptr <= commit_ptr + (AW+1)'(wr.len);
        dwp        <= dwp + (DW+1)'(1);
      end
      if (rd.rd_en) begin
        rd_ptr <= rd_ptr + (AW+1)'(1);
      end
      if (rd.pop) begin
        drp <= drp + (DW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.commit) begin
      dq[dwp[DW-1:0]] <= wr.len;
    end
  end

endmodule
`default_nettype wire

/* src/mie_back.sv */
// Run emitter: reads committed SSID bytes and drives the result channel.
`default_nettype none
module mie_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire mie_pkg::q_desc_t desc,
  input  wire logic [7:0]   rdata,
  output mie_pkg::q_rd_t    rd,
  mie_ssid_if.source        ssid
);
  import mie_pkg::*;

  logic             run_active;
  logic [IDX_W-1:0] run_idx;
  logic [LEN_W-1:0] run_len;
  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic [LEN_W-1:0] s1_len;
  logic             s1_last;
  logic             s2_valid;

  logic [IDX_W-1:0] cur_idx;
  logic [LEN_W-1:0] cur_len;
  logic             avail, s2_free, issue, last_c;

  always_comb begin
    cur_idx = run_active ? run_idx : '0;
    cur_len = run_active ? run_len : desc.len;
    avail   = run_active || desc.valid;
    s2_free = !s2_valid || ssid.ready;
    issue   = avail && (!s1_valid || s2_free);
    last_c  = (LEN_W'(cur_idx) + LEN_W'(1)) == cur_len;
    rd.rd_en = issue;
    rd.pop   = issue && !run_active;
  end

  assign ssid.valid = s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      if (issue) begin
        run_active <= !last_c;
      end
      s1_valid <= issue || (s1_valid && !s2_free);
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      run_idx <= cur_idx + IDX_W'(1);
      run_len <= cur_len;
      s1_idx  <= cur_idx;
      s1_len  <= cur_len;
      s1_last <= last_c;
    end
    if (s1_valid && s2_free) begin
      ssid.ssid_byte   <= rdata;
      ssid.ssid_index  <= s1_idx;
      ssid.ssid_length <= s1_len;
      ssid.last        <= s1_last;
    end
  end

endmodule
`default_nettype wire

/* src/mgmt_ie_ssid_extractor_core.sv */
// Top level of the management frame SSID extractor.
//
//   channel  dir  handshake      payload
//   frame    in   valid/ready    data_byte, frame_start, frame_end, fixed_len
//   ssid     out  valid/ready    ssid_byte, ssid_index, ssid_length, last
//
// One frame byte is taken per cycle while frame.ready is high; the walker
// decides each byte in that cycle. An SSID run of N bytes leaves one item
// per cycle while ssid.ready is high, after commit, via the registered read.
// frame.ready drops while more than BYTE_DEPTH-32 committed bytes or
// DESC_DEPTH runs wait to be sent; a stalled ssid side only fills the queue.
// Synchronous reset clears the parser, the stored SSID and the queue pointers.
`default_nettype none
module mgmt_ie_ssid_extractor_core #(
  parameter int BYTE_DEPTH = mie_pkg::BYTE_DEPTH_DEF,
  parameter int DESC_DEPTH = mie_pkg::DESC_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mie_frame_if.sink   frame,
  mie_ssid_if.source  ssid
);
  import mie_pkg::*;

  q_wr_t      wr;
  q_rd_t      rd;
  q_desc_t    desc;
  logic       space_ok;
  logic [7:0] rdata;

  mie_front u_front (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame),
    .space_ok(space_ok),
    .wr      (wr)
  );

  mie_queue #(
    .BYTE_DEPTH(BYTE_DEPTH),
    .DESC_DEPTH(DESC_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .space_ok(space_ok),
    .rd      (rd),
    .desc    (desc),
    .rdata   (rdata)
  );

  mie_back u_back (
    .clk  (clk),
    .rst  (rst),
    .desc (desc),
    .rdata(rdata),
    .rd   (rd),
    .ssid (ssid)
  );

endmodule
`default_nettype wire
